### hw/rtl/cfd_pkg.sv
// Shared types and constants for the COBS frame decoder.
// No dependencies; used by every module under hw/rtl.
package cfd_pkg;

  // Width of the frame length counter (8 to 16)
  localparam int CFD_LEN_W = 16;
  localparam logic [15:0] LEN_MAX16 = 16'((1 << CFD_LEN_W) - 1);

  // A run of this many data bytes (code 0xFF) owes no zero
  localparam logic [7:0] FULL_RUN_LEN = 8'hFE;

  // Configuration register map
  localparam int REG_MAX_FRAME_LEN = 0;
  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd254;

  // Result queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DELIM  = 2'd1,
    STATUS_LENGTH = 2'd2
  } status_t;

  // One result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    status_t     frame_status;
    logic [15:0] frame_length;
  } result_t;

endpackage

### hw/rtl/cfd_front.sv
// Front end of the COBS frame decoder: accepts encoded bytes, tracks run and
// frame state and produces at most one result item per byte.
// Depends on cfd_pkg.
module cfd_front import cfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic [15:0]   max_frame_len,
  output logic          push,
  output result_t       push_data
);

  logic [7:0]           run_remaining_r, run_remaining_nxt;
  logic                 expect_code_r, expect_code_nxt;
  logic                 zero_owed_r, zero_owed_nxt;
  logic                 frame_started_r, frame_started_nxt;
  logic [CFD_LEN_W-1:0] bytes_written_r, bytes_written_nxt;
  status_t              error_held_r, error_held_nxt;

  logic [15:0]          limit16;
  logic [CFD_LEN_W-1:0] limit;
  logic [CFD_LEN_W-1:0] bw_after_zero;
  logic [CFD_LEN_W-1:0] room;
  logic [7:0]           run;
  logic                 at_limit;

  // Effective limit, capped to the counter range
  assign limit16 = (max_frame_len > LEN_MAX16) ? LEN_MAX16 : max_frame_len;
  assign limit   = limit16[CFD_LEN_W-1:0];

  assign run      = rx_byte - 8'd1;
  assign at_limit = (bytes_written_r >= limit);

  // Count after the owed zero (if any) goes out
  assign bw_after_zero = zero_owed_r ? (bytes_written_r + CFD_LEN_W'(1)) : bytes_written_r;
  assign room = (bw_after_zero >= limit) ? '0 : (limit - bw_after_zero);

  // Decode one byte
  always_comb begin
    run_remaining_nxt = run_remaining_r;
    expect_code_nxt   = expect_code_r;
    zero_owed_nxt     = zero_owed_r;
    frame_started_nxt = frame_started_r;
    bytes_written_nxt = bytes_written_r;
    error_held_nxt    = error_held_r;
    push              = 1'b0;
    push_data         = '0;

    if (accept) begin
      if (error_held_r != STATUS_OK) begin
        // Discarding until the delimiter
        if (rx_byte == 8'd0) begin
          push                   = 1'b1;
          push_data.frame_end    = 1'b1;
          push_data.frame_status = error_held_r;
          push_data.frame_length = 16'(bytes_written_r);
        end
      end else if (!expect_code_r) begin
        if (rx_byte == 8'd0) begin
          // Delimiter inside a run
          push                   = 1'b1;
          push_data.frame_end    = 1'b1;
          push_data.frame_status = STATUS_DELIM;
          push_data.frame_length = 16'(bytes_written_r);
        end else begin
          push                 = 1'b1;
          push_data.out_byte   = rx_byte;
          push_data.byte_valid = 1'b1;
          bytes_written_nxt    = bytes_written_r + CFD_LEN_W'(1);
          run_remaining_nxt    = run_remaining_r - 8'd1;
          expect_code_nxt      = (run_remaining_r == 8'd1);
        end
      end else if (rx_byte == 8'd0) begin
        // Delimiter in code position
        push                   = 1'b1;
        push_data.frame_end    = 1'b1;
        push_data.frame_length = 16'(bytes_written_r);
        if (!frame_started_r) begin
          push_data.frame_status = STATUS_DELIM;
        end else if (bytes_written_r == '0) begin
          push_data.frame_status = STATUS_LENGTH;
        end else begin
          push_data.frame_status = STATUS_OK;
        end
      end else begin
        // Code byte
        frame_started_nxt = 1'b1;
        zero_owed_nxt     = 1'b0;
        if (zero_owed_r && at_limit) begin
          error_held_nxt = STATUS_LENGTH;
        end else begin
          if (zero_owed_r) begin
            push                 = 1'b1;
            push_data.byte_valid = 1'b1;
          end
          bytes_written_nxt = bw_after_zero;
          if (CFD_LEN_W'(run) > room) begin
            error_held_nxt = STATUS_LENGTH;
          end else begin
            run_remaining_nxt = run;
            zero_owed_nxt     = (run != FULL_RUN_LEN);
            expect_code_nxt   = (run == 8'd0);
          end
        end
      end

      // Any frame end clears the frame state
      if (push_data.frame_end) begin
        run_remaining_nxt = '0;
        expect_code_nxt   = 1'b1;
        zero_owed_nxt     = 1'b0;
        frame_started_nxt = 1'b0;
        bytes_written_nxt = '0;
        error_held_nxt    = STATUS_OK;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_remaining_r <= '0;
      expect_code_r   <= 1'b1;
      zero_owed_r     <= 1'b0;
      frame_started_r <= 1'b0;
      bytes_written_r <= '0;
      error_held_r    <= STATUS_OK;
    end else begin
      run_remaining_r <= run_remaining_nxt;
      expect_code_r   <= expect_code_nxt;
      zero_owed_r     <= zero_owed_nxt;
      frame_started_r <= frame_started_nxt;
      bytes_written_r <= bytes_written_nxt;
      error_held_r    <= error_held_nxt;
    end
  end

endmodule

### hw/rtl/cfd_back.sv
// Back end of the COBS frame decoder: a short result queue that holds
// decoded items and presents them on the output handshake.
// Depends on cfd_pkg.
module cfd_back import cfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    not_full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign not_full  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/cobs_frame_decoder.sv
// Streaming COBS frame decoder, top level with the configuration port.
// Each result is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while the two-entry result queue, which
// sets in_ready, has room: input flows on while one result waits to be taken.
// Reset (rst_n low, synchronous): queue empty, frame state cleared,
// max_frame_len back to 254. Depends on cfd_pkg, cfd_front, cfd_back.
module cobs_frame_decoder import cfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Encoded byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // Decoded result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_end,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_frame_length,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_frame_len_r;
  logic        cfg_wr;
  logic        accept;
  logic        push;
  result_t     push_data;
  result_t     out_data;
  logic        q_not_full;

  // Configuration register (single word at offset 0)
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (32'(paddr >> 2) == 32'(REG_MAX_FRAME_LEN));
  assign prdata = 32'(max_frame_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_len_r <= MAX_FRAME_LEN_RST;
    end else if (cfg_wr) begin
      max_frame_len_r <= pwdata[15:0];
    end
  end

  // Input handshake
  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;

  cfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_rx_byte),
    .max_frame_len (max_frame_len_r),
    .push          (push),
    .push_data     (push_data)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result fields
  assign out_byte         = out_data.out_byte;
  assign out_byte_valid   = out_data.byte_valid;
  assign out_frame_end    = out_data.frame_end;
  assign out_frame_status = out_data.frame_status;
  assign out_frame_length = out_data.frame_length;

endmodule
